FILE: hw/rtl/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg: shared constants and types for the dead band motor command block
// Register indexes, reset values, drive limits and the pipeline side tag.
// ----------------------------------------------------------------------------
`default_nettype none

package dbm_pkg;

  // Default sensor sample width
  localparam int SAMPLE_BITS_DEF = 10;

  // Configuration register widths
  localparam int MID_W  = 10;
  localparam int EP_W   = 12;
  localparam int BAND_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MID_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ENDPOINT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENDPOINT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 2'd3;

  // Reset values
  localparam logic [MID_W-1:0]         MID_RST  = 10'd645;
  localparam logic signed [EP_W-1:0]   LOW_RST  = 12'sd88;
  localparam logic signed [EP_W-1:0]   HIGH_RST = 12'sd1024;
  localparam logic [BAND_W-1:0]        BAND_RST = 8'd5;

  // Drive limits and output widths
  localparam int MAG_W   = 6;
  localparam int DRIVE_W = 7;
  localparam int DIR_W   = 2;
  localparam int BYTE_W  = 8;
  localparam logic [MAG_W-1:0] DRIVE_LIMIT = 6'd60;
  localparam logic [MAG_W-1:0] MIN_VOLTAGE = 6'd6;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_COAST   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

  // Quotient bits kept by the divider (anything >= 2**QUO_BITS saturates)
  localparam int QUO_BITS = 6;
  // Divisor magnitude width: |endpoint +/- band| stays below 4096
  localparam int DEN_W = 12;

  // Side information that travels with each item through the divider
  typedef struct packed {
    logic valid;  // item present in this stage
    logic neg;    // result is negative
    logic zero;   // drive forced to zero (dead band or zero divisor)
    logic sat;    // quotient at or beyond 2**QUO_BITS
  } dbm_tag_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dbm_div.sv
// ----------------------------------------------------------------------------
// dbm_div: pipelined restoring divider, one quotient bit per stage
// Divides an unsigned numerator by an unsigned divisor whose quotient is
// known to fit QUO_BITS bits; the tag rides along with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module dbm_div #(
  parameter int NUM_W = 18
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dbm_pkg::dbm_tag_t               tag_i,
  input  logic [NUM_W-1:0]                num_i,
  input  logic [dbm_pkg::DEN_W-1:0]       den_i,
  output dbm_pkg::dbm_tag_t               tag_o,
  output logic [dbm_pkg::QUO_BITS-1:0]    quo_o
);
  import dbm_pkg::*;

  localparam int CW = NUM_W + DEN_W;

  dbm_tag_t            tag_r [QUO_BITS];
  logic [NUM_W-1:0]    rem_r [QUO_BITS];
  logic [DEN_W-1:0]    den_r [QUO_BITS];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS];

  dbm_tag_t            src_tag [QUO_BITS];
  logic [NUM_W-1:0]    src_rem [QUO_BITS];
  logic [DEN_W-1:0]    src_den [QUO_BITS];
  logic [QUO_BITS-1:0] src_quo [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [CW-1:0]       dsh;
    logic                take;
    logic [NUM_W-1:0]    rem_nxt;
    logic [QUO_BITS-1:0] quo_nxt;

    // stage input: module input for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign src_tag[k] = tag_i;
      assign src_rem[k] = num_i;
      assign src_den[k] = den_i;
      assign src_quo[k] = '0;
    end else begin : g_next
      assign src_tag[k] = tag_r[k-1];
      assign src_rem[k] = rem_r[k-1];
      assign src_den[k] = den_r[k-1];
      assign src_quo[k] = quo_r[k-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      dsh     = CW'(src_den[k]) << (QUO_BITS - 1 - k);
      take    = (CW'(src_rem[k]) >= dsh);
      rem_nxt = take ? NUM_W'(CW'(src_rem[k]) - dsh) : src_rem[k];
      quo_nxt = {src_quo[k][QUO_BITS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else begin
        tag_r[k] <= src_tag[k];
      end
      rem_r[k] <= rem_nxt;
      den_r[k] <= src_den[k];
      quo_r[k] <= quo_nxt;
    end
  end

  assign tag_o = tag_r[QUO_BITS-1];
  assign quo_o = quo_r[QUO_BITS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/deadband_map_motor_command.sv
// ----------------------------------------------------------------------------
// deadband_map_motor_command: sensor sample to motor-driver control byte
// Pipeline of 4 front stages, 6 divider stages and 1 output stage between start
// and out_valid; throughput one item per cycle, busy is always low.
// Synchronous active-low reset clears the valid bits and loads the config
// registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module deadband_map_motor_command #(
  parameter int SAMPLE_BITS = dbm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item input
  input  logic                                 start,
  output logic                                 busy,
  input  logic [SAMPLE_BITS-1:0]               in_sensor_sample,
  // result output
  output logic                                 out_valid,
  output logic signed [dbm_pkg::DRIVE_W-1:0]   out_drive_value,
  output logic [dbm_pkg::DIR_W-1:0]            out_direction_code,
  output logic [dbm_pkg::MAG_W-1:0]            out_voltage_code,
  output logic [dbm_pkg::BYTE_W-1:0]           out_control_byte,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dbm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dbm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dbm_pkg::*;

  localparam int EW  = ((SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W) + 1; // x width
  localparam int TW  = EW + 1;       // x +/- band, signed
  localparam int MW  = EW;           // |x +/- band|
  localparam int NW  = MW + MAG_W;   // |t| * 60
  localparam int CW  = NW + DEN_W;   // compare width
  localparam int DSW = DEN_W + 1;    // signed divisor
  localparam int LAT = QUO_BITS + 5;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MID_W-1:0]       mid_level_r;
  logic signed [EP_W-1:0] low_endpoint_r;
  logic signed [EP_W-1:0] high_endpoint_r;
  logic [BAND_W-1:0]      dead_band_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_level_r     <= MID_RST;
      low_endpoint_r  <= LOW_RST;
      high_endpoint_r <= HIGH_RST;
      dead_band_r     <= BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MID_LEVEL:     mid_level_r     <= cfg_data[MID_W-1:0];
        REG_LOW_ENDPOINT:  low_endpoint_r  <= $signed(cfg_data[EP_W-1:0]);
        REG_HIGH_ENDPOINT: high_endpoint_r <= $signed(cfg_data[EP_W-1:0]);
        REG_DEAD_BAND:     dead_band_r     <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: center the sample, divide by 4 toward zero
  // --------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic signed [EW-1:0] s1_x_r;
  logic signed [EW-1:0] diff;
  logic signed [EW-1:0] diff_b;
  logic signed [EW-1:0] s1_x_nxt;

  always_comb begin
    diff     = $signed(EW'(in_sensor_sample) - EW'(mid_level_r));
    diff_b   = diff[EW-1] ? (diff + EW'(3)) : diff;
    s1_x_nxt = diff_b >>> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_x_r <= s1_x_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 2: band test, pick segment, form |t| and the signed divisor
  // --------------------------------------------------------------------------
  logic                  s2_valid_r;
  logic                  s2_active_r;
  logic [MW-1:0]         s2_tmag_r;
  logic [DEN_W-1:0]      s2_den_mag_r;
  logic                  s2_den_neg_r;
  logic                  s2_den_zero_r;

  logic signed [TW-1:0]  xe;
  logic signed [TW-1:0]  band_e;
  logic signed [TW-1:0]  tsum;
  logic signed [TW-1:0]  tdif;
  logic                  below;
  logic                  above;
  logic signed [DSW-1:0] band_d;
  logic signed [DSW-1:0] den_s;
  logic signed [DSW-1:0] den_abs;
  logic [MW-1:0]         s2_tmag_nxt;

  always_comb begin
    xe          = $signed({s1_x_r[EW-1], s1_x_r});
    band_e      = $signed(TW'(dead_band_r));
    tsum        = xe + band_e;
    tdif        = xe - band_e;
    below       = (xe < -band_e);
    above       = (xe > band_e);
    s2_tmag_nxt = below ? MW'(-tsum) : MW'(tdif);
    band_d      = $signed(DSW'(dead_band_r));
    den_s       = below ? ($signed({low_endpoint_r[EP_W-1], low_endpoint_r}) + band_d)
                        : ($signed({high_endpoint_r[EP_W-1], high_endpoint_r}) - band_d);
    den_abs     = den_s[DSW-1] ? -den_s : den_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_active_r   <= below || above;
    s2_tmag_r     <= s2_tmag_nxt;
    s2_den_mag_r  <= den_abs[DEN_W-1:0];
    s2_den_neg_r  <= den_s[DSW-1];
    s2_den_zero_r <= (den_s == '0);
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerator magnitude |t| * 60 (numerator itself is never positive)
  // --------------------------------------------------------------------------
  dbm_tag_t         s3_tag_r;
  dbm_tag_t         s3_tag_nxt;
  logic [NW-1:0]    s3_num_r;
  logic [DEN_W-1:0] s3_den_r;

  always_comb begin
    s3_tag_nxt.valid = s2_valid_r;
    s3_tag_nxt.neg   = !s2_den_neg_r;
    s3_tag_nxt.zero  = !s2_active_r || s2_den_zero_r;
    s3_tag_nxt.sat   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
    end else begin
      s3_tag_r <= s3_tag_nxt;
    end
    s3_num_r <= NW'(s2_tmag_r) * NW'(DRIVE_LIMIT);
    s3_den_r <= s2_den_mag_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: saturation check, quotient would not fit QUO_BITS bits
  // --------------------------------------------------------------------------
  dbm_tag_t         s4_tag_r;
  dbm_tag_t         s4_tag_nxt;
  logic [NW-1:0]    s4_num_r;
  logic [DEN_W-1:0] s4_den_r;

  always_comb begin
    s4_tag_nxt     = s3_tag_r;
    s4_tag_nxt.sat = (CW'(s3_num_r) >= (CW'(s3_den_r) << QUO_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r <= '0;
    end else begin
      s4_tag_r <= s4_tag_nxt;
    end
    s4_num_r <= s4_tag_nxt.sat ? '0 : s3_num_r;
    s4_den_r <= s3_den_r;
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage
  // --------------------------------------------------------------------------
  dbm_tag_t            dv_tag;
  logic [QUO_BITS-1:0] dv_quo;

  dbm_div #(
    .NUM_W (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (s4_tag_r),
    .num_i (s4_num_r),
    .den_i (s4_den_r),
    .tag_o (dv_tag),
    .quo_o (dv_quo)
  );

  // --------------------------------------------------------------------------
  // Output stage: clamp, sign split, minimum voltage, pack control byte
  // --------------------------------------------------------------------------
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic [DIR_W-1:0]          dir_r;
  logic [MAG_W-1:0]          volt_r;

  logic [MAG_W-1:0]          mag;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic [DIR_W-1:0]          dir_nxt;
  logic [MAG_W-1:0]          volt_nxt;

  always_comb begin
    if (dv_tag.zero) begin
      mag = '0;
    end else if (dv_tag.sat || (MAG_W'(dv_quo) > DRIVE_LIMIT)) begin
      mag = DRIVE_LIMIT;
    end else begin
      mag = MAG_W'(dv_quo);
    end
    drive_nxt = dv_tag.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (mag == '0) begin
      dir_nxt = DIR_COAST;
    end else if (dv_tag.neg) begin
      dir_nxt = DIR_REVERSE;
    end else begin
      dir_nxt = DIR_FORWARD;
    end
    volt_nxt = (mag < MIN_VOLTAGE) ? MIN_VOLTAGE : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_tag.valid;
    end
    drive_r <= drive_nxt;
    dir_r   <= dir_nxt;
    volt_r  <= volt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_drive_value    = drive_r;
  assign out_direction_code = dir_r;
  assign out_voltage_code   = volt_r;
  assign out_control_byte   = {volt_r, dir_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // every accepted item yields a result a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("item result missing at fixed latency");

  // voltage code stays within its floor and the drive limit
  a_volt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_voltage_code >= MIN_VOLTAGE) && (out_voltage_code <= DRIVE_LIMIT))
    else $error("voltage code out of range");

  // coast only with zero drive, and direction agrees with drive sign
  a_dir_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_direction_code == DIR_COAST) == (out_drive_value == 0)) &&
                  ((out_direction_code == DIR_REVERSE) == (out_drive_value < 0)))
    else $error("direction code disagrees with drive value");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for deadband_map_motor_command
// Drives light-sensor samples through the start/busy port under several
// register settings. Every accepted sample gets an expected motor command
// from a local dead-band/linear-map predictor, or a hand-typed one for the
// obvious cases. Each out_valid strobe is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import dbm_pkg::*;

  localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 5;
  localparam int PIPE_LATENCY    = 11;
  localparam int DRAIN_CYCLES    = 3 * PIPE_LATENCY;
  localparam int STALL_LIMIT     = 500;
  localparam int PHASES          = 17;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PRINT_LIMIT     = 100;

  // One motor command as it leaves the block
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [DIR_W-1:0]          dir;
    logic [MAG_W-1:0]          volt;
    logic [BYTE_W-1:0]         ctrl;
  } motor_cmd_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // Directed row: a register write, or a sample with an optional typed command
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    int                   value;
    logic                 typed;
    motor_cmd_t           cmd;
  } stim_row_t;

  localparam motor_cmd_t NO_CMD      = '0;
  localparam motor_cmd_t CMD_COAST   = '{7'sd0, DIR_COAST, 6'd6, 8'h18};
  localparam motor_cmd_t CMD_FWD_MAX = '{7'sd60, DIR_FORWARD, 6'd60, 8'hF1};
  localparam motor_cmd_t CMD_REV_MAX = '{-7'sd60, DIR_REVERSE, 6'd60, 8'hF2};
  localparam motor_cmd_t CMD_REV_MIN = '{-7'sd5, DIR_REVERSE, 6'd6, 8'h1A};

  localparam int N_ROWS = 43;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    // reset settings: center, both rails, band edges
    '{ROW_ITEM, '0, 645, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 0, 1'b1, CMD_REV_MAX},
    '{ROW_ITEM, '0, 1023, 1'b1, CMD_REV_MIN},
    '{ROW_ITEM, '0, 625, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 669, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 621, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 300, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 900, 1'b0, NO_CMD},
    // no band, symmetric slopes; truncation toward zero near center
    '{ROW_CFG, REG_MID_LEVEL, 512, 1'b0, NO_CMD},
    '{ROW_CFG, REG_DEAD_BAND, 0, 1'b0, NO_CMD},
    '{ROW_CFG, REG_LOW_ENDPOINT, -128, 1'b0, NO_CMD},
    '{ROW_CFG, REG_HIGH_ENDPOINT, 128, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 512, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 511, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 508, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 0, 1'b1, CMD_FWD_MAX},
    '{ROW_ITEM, '0, 1023, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 256, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 700, 1'b0, NO_CMD},
    // endpoints on the band edges: zero divisor on each side
    '{ROW_CFG, REG_DEAD_BAND, 10, 1'b0, NO_CMD},
    '{ROW_CFG, REG_LOW_ENDPOINT, -10, 1'b0, NO_CMD},
    '{ROW_CFG, REG_HIGH_ENDPOINT, 10, 1'b0, NO_CMD},
    '{ROW_CFG, REG_MID_LEVEL, 0, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 1023, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 20, 1'b0, NO_CMD},
    '{ROW_CFG, REG_MID_LEVEL, 1023, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 0, 1'b1, CMD_COAST},
    // one-count segments: map result far past the limit
    '{ROW_CFG, REG_DEAD_BAND, 0, 1'b0, NO_CMD},
    '{ROW_CFG, REG_LOW_ENDPOINT, -1, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 0, 1'b1, CMD_FWD_MAX},
    '{ROW_ITEM, '0, 1000, 1'b0, NO_CMD},
    '{ROW_CFG, REG_MID_LEVEL, 0, 1'b0, NO_CMD},
    '{ROW_CFG, REG_HIGH_ENDPOINT, 1, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 1023, 1'b1, CMD_REV_MAX},
    // widest band and endpoint extremes
    '{ROW_CFG, REG_DEAD_BAND, 255, 1'b0, NO_CMD},
    '{ROW_CFG, REG_LOW_ENDPOINT, -1024, 1'b0, NO_CMD},
    '{ROW_CFG, REG_HIGH_ENDPOINT, 1024, 1'b0, NO_CMD},
    '{ROW_CFG, REG_MID_LEVEL, 1023, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 0, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 1023, 1'b1, CMD_COAST},
    '{ROW_CFG, REG_MID_LEVEL, 0, 1'b0, NO_CMD},
    '{ROW_ITEM, '0, 1023, 1'b1, CMD_COAST},
    '{ROW_ITEM, '0, 512, 1'b0, NO_CMD}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [SAMPLE_W-1:0]         in_sensor_sample = '0;
  logic                        out_valid;
  logic signed [DRIVE_W-1:0]   out_drive_value;
  logic [DIR_W-1:0]            out_direction_code;
  logic [MAG_W-1:0]            out_voltage_code;
  logic [BYTE_W-1:0]           out_control_byte;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // Local copy of the register file
  logic [MID_W-1:0]            model_mid = MID_RST;
  logic signed [EP_W-1:0]      model_low = LOW_RST;
  logic signed [EP_W-1:0]      model_high = HIGH_RST;
  logic [BAND_W-1:0]           model_band = BAND_RST;

  motor_cmd_t                  expected_cmds [$];
  int                          error_count = 0;
  int                          result_count = 0;
  int                          stall_cycles = 0;

  deadband_map_motor_command #(
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sensor_sample  (in_sensor_sample),
    .out_valid         (out_valid),
    .out_drive_value   (out_drive_value),
    .out_direction_code(out_direction_code),
    .out_voltage_code  (out_voltage_code),
    .out_control_byte  (out_control_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t ERROR: %s", $time, msg);
    end
  endtask

  // Sample -> centered/4 -> dead band or linear map -> clamp -> sign split
  function automatic motor_cmd_t predict_command(input logic [SAMPLE_W-1:0] sample);
    longint     x;
    longint     band;
    longint     span;
    longint     drv;
    longint     lim;
    motor_cmd_t cmd;
    lim  = longint'(DRIVE_LIMIT);
    band = longint'(model_band);
    x    = (longint'(sample) - longint'(model_mid)) / 4;
    if (x >= -band && x <= band) begin
      drv = 0;
    end else if (x < -band) begin
      span = longint'(model_low) + band;
      drv  = (span == 0) ? 0 : (x + band) * lim / span;
    end else begin
      span = longint'(model_high) - band;
      drv  = (span == 0) ? 0 : (x - band) * -lim / span;
    end
    if (drv > lim) drv = lim;
    if (drv < -lim) drv = -lim;
    cmd.drive = DRIVE_W'(drv);
    if (drv > 0) begin
      cmd.dir  = DIR_FORWARD;
      cmd.volt = MAG_W'(drv);
    end else if (drv == 0) begin
      cmd.dir  = DIR_COAST;
      cmd.volt = '0;
    end else begin
      cmd.dir  = DIR_REVERSE;
      cmd.volt = MAG_W'(-drv);
    end
    if (cmd.volt < MIN_VOLTAGE) cmd.volt = MIN_VOLTAGE;
    cmd.ctrl = {cmd.volt, cmd.dir};
    return cmd;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Rails, a window around the band edges, or anywhere
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int s;
    int b;
    b = int'(model_band);
    case ($urandom_range(0, 9))
      0: s = 0;
      1: s = SAMPLE_MAX;
      2, 3, 4, 5: begin
        s = int'(model_mid) + 4 * (int'($urandom_range(0, 2 * b + 16)) - (b + 8))
            + int'($urandom_range(0, 3));
        if (s < 0) s = 0;
        if (s > SAMPLE_MAX) s = SAMPLE_MAX;
      end
      default: s = $urandom_range(0, SAMPLE_MAX);
    endcase
    return SAMPLE_W'(s);
  endfunction

  // Register data; unused upper bits of the narrow registers carry junk
  function automatic logic [CFG_DATA_W-1:0] pick_mid();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 3))
      0: d[MID_W-1:0] = '0;
      1: d[MID_W-1:0] = '1;
      default: d[MID_W-1:0] = MID_W'($urandom);
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_band();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0: d[BAND_W-1:0] = '0;
      1: d[BAND_W-1:0] = '1;
      2, 3: d[BAND_W-1:0] = BAND_W'($urandom_range(0, 15));
      default: d[BAND_W-1:0] = BAND_W'($urandom);
    endcase
    return d;
  endfunction

  // Endpoint relative to the current band: extremes, flat, steep or random
  function automatic logic [CFG_DATA_W-1:0] pick_endpoint(input bit upper);
    int b;
    int v;
    b = int'(model_band);
    case ($urandom_range(0, 5))
      0: v = -1024;
      1: v = 1024;
      2: v = upper ? b : -b;
      3: v = upper ? b + int'($urandom_range(1, 3)) : -b - int'($urandom_range(1, 3));
      default: v = int'($urandom_range(0, 2048)) - 1024;
    endcase
    return CFG_DATA_W'(v);
  endfunction

  // Register write; valid stays up when another write follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      REG_MID_LEVEL:     model_mid  = data[MID_W-1:0];
      REG_LOW_ENDPOINT:  model_low  = data[EP_W-1:0];
      REG_HIGH_ENDPOINT: model_high = data[EP_W-1:0];
      REG_DEAD_BAND:     model_band = data[BAND_W-1:0];
      default: ;
    endcase
  endtask

  // Present one sample, record its expected command once accepted
  task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic typed,
                           input motor_cmd_t typed_cmd, input int gap);
    start            <= 1'b1;
    in_sensor_sample <= sample;
    do @(posedge clk); while (busy);
    expected_cmds.push_back(typed ? typed_cmd : predict_command(sample));
    if (gap > 0) begin
      start            <= 1'b0;
      in_sensor_sample <= SAMPLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new samples until every pending command has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_cmds.size() == 0) begin
        note_error($sformatf("result %0d with nothing pending, control byte %02h",
                             result_count, out_control_byte));
      end else begin
        want = expected_cmds.pop_front();
        if (out_drive_value !== want.drive)
          note_error($sformatf("result %0d drive_value %0d, want %0d",
                               result_count, out_drive_value, want.drive));
        if (out_direction_code !== want.dir)
          note_error($sformatf("result %0d direction_code %0d, want %0d",
                               result_count, out_direction_code, want.dir));
        if (out_voltage_code !== want.volt)
          note_error($sformatf("result %0d voltage_code %0d, want %0d",
                               result_count, out_voltage_code, want.volt));
        if (out_control_byte !== want.ctrl)
          note_error($sformatf("result %0d control_byte %02h, want %02h",
                               result_count, out_control_byte, want.ctrl));
      end
    end
  end

  // Watchdog: too long without any handshake or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bit burst;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        if (r > 0 && DIRECTED_ROWS[r-1].kind == ROW_ITEM) wait_idle();
        write_reg(DIRECTED_ROWS[r].reg_index, CFG_DATA_W'(DIRECTED_ROWS[r].value),
                  r + 1 == N_ROWS || DIRECTED_ROWS[r+1].kind != ROW_CFG);
      end else begin
        send_item(SAMPLE_W'(DIRECTED_ROWS[r].value), DIRECTED_ROWS[r].typed,
                  DIRECTED_ROWS[r].cmd, pick_gap());
      end
    end

    // random phases, new settings each time; band goes first, endpoints track it
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_DEAD_BAND, pick_band(), 1'b0);
      write_reg(REG_MID_LEVEL, pick_mid(), 1'b0);
      write_reg(REG_LOW_ENDPOINT, pick_endpoint(1'b0), 1'b0);
      write_reg(REG_HIGH_ENDPOINT, pick_endpoint(1'b1), 1'b1);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(pick_sample(), 1'b0, NO_CMD, burst ? 0 : pick_gap());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cmds.size() != 0)
      note_error($sformatf("%0d commands never arrived", expected_cmds.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
